// ----- sv/sssc_pkg.sv -----
// Package for the stack-sortable sequence checker.
// Holds the field widths and the sequencer state type; depends on nothing.
`default_nettype none

package sssc_pkg;

	// Width of one sequence value and of the expected-next counter.
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned EXP_W   = VALUE_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAKE,
		ST_POP_WAIT,
		ST_FINAL,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- sv/stack_sortable_sequence_check.sv -----
// Top level of the stack-sortable sequence checker: sequencer, stack memory and registers.
// Depends on sssc_pkg for widths and the sequencer state type.
`default_nettype none

// The block takes the values of a run one request at a time on the value channel and
// decides whether the run can be emitted as 1, 2, ..., n through a single auxiliary stack,
// where n is the sequence_length register. A value equal to the expected one passes; any
// other value first drains matching tops from the stack, then fails the run if the top is
// smaller, else is pushed. The request marked last drains the stack and produces one result
// request carrying sortable and stack_overflowed; after that the run state returns to its
// reset values while sequence_length is kept. After a failure the rest of the run is ignored.
// A push into a full stack (STACK_DEPTH entries) is dropped and reported in stack_overflowed.
// Steps: a value that passes, is pushed, fails or overflows is accepted in the idle state,
// then evaluated. Every pop that leaves the stack non-empty adds a wait state, since the
// new top of stack has to be fetched from the stack memory, whose read data is registered,
// and then a fresh evaluation; the pop that empties the stack adds only the evaluation. The
// last request adds the final check of the stack and the verdict, plus any wait for the
// result register to be free. The next value can be accepted while a verdict still waits
// on the result channel. sequence_length may only be written while no run is in progress.
module stack_sortable_sequence_check #(
	parameter int unsigned STACK_DEPTH = 128
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// Configuration: n, the length of the run.
	input  wire                              sequence_length_we,
	input  wire  [sssc_pkg::VALUE_W-1:0]     sequence_length_wdata,
	// Input requests.
	input  wire                              value_valid,
	output logic                             value_stall,
	input  wire  [sssc_pkg::VALUE_W-1:0]     value,
	input  wire                              last,
	// Result requests.
	output logic                             result_valid,
	input  wire                              result_stall,
	output logic                             sortable,
	output logic                             stack_overflowed
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned VW = sssc_pkg::VALUE_W;
	localparam int unsigned EW = sssc_pkg::EXP_W;

	// The stack itself; only entries below the fill count are ever read.
	logic [VW-1:0] stack_mem [STACK_DEPTH];
	logic [VW-1:0] rd_data_q;

	sssc_pkg::state_t state_q, state_d;
	sssc_pkg::state_t ret_q, ret_d;

	logic [VW-1:0] length_q;
	logic [VW-1:0] value_q;
	logic          last_q;
	logic [VW-1:0] top_q, top_d;
	logic [CW-1:0] count_q, count_d;
	logic [EW-1:0] exp_q, exp_d;
	logic          failed_q, failed_d;
	logic          ovf_q, ovf_d;
	logic          draining_q, draining_d;
	logic          res_valid_q, res_valid_d;
	logic          res_sortable_q, res_sortable_d;
	logic          res_ovf_q, res_ovf_d;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	logic          accept;
	logic          stack_empty;
	logic          stack_full;
	logic          top_is_exp;
	logic          slot_free;
	logic [CW-1:0] count_dec;

	assign accept      = value_valid && !value_stall;
	assign stack_empty = (count_q == '0);
	assign stack_full  = (count_q == CW'(STACK_DEPTH));
	assign top_is_exp  = ({1'b0, top_q} == exp_q);
	assign slot_free   = !res_valid_q || !result_stall;
	assign count_dec   = count_q - CW'(1);

	// Only one request is worked on at a time; the input side waits outside the idle state.
	assign value_stall      = (state_q != sssc_pkg::ST_IDLE);
	assign result_valid     = res_valid_q;
	assign sortable         = res_sortable_q;
	assign stack_overflowed = res_ovf_q;

	// Stack memory: one write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= value_q;
		end
		if (mem_re) begin
			rd_data_q <= stack_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sssc_pkg::ST_IDLE;
			ret_q          <= sssc_pkg::ST_TAKE;
			length_q       <= '0;
			count_q        <= '0;
			exp_q          <= EW'(1);
			failed_q       <= 1'b0;
			ovf_q          <= 1'b0;
			draining_q     <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			count_q     <= count_d;
			exp_q       <= exp_d;
			failed_q    <= failed_d;
			ovf_q       <= ovf_d;
			draining_q  <= draining_d;
			res_valid_q <= res_valid_d;
			if (sequence_length_we) begin
				length_q <= sequence_length_wdata;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
			last_q  <= last;
		end
		top_q          <= top_d;
		res_sortable_q <= res_sortable_d;
		res_ovf_q      <= res_ovf_d;
	end

	always_comb begin
		state_d        = state_q;
		ret_d          = ret_q;
		top_d          = top_q;
		count_d        = count_q;
		exp_d          = exp_q;
		failed_d       = failed_q;
		ovf_d          = ovf_q;
		draining_d     = draining_q;
		res_valid_d    = res_valid_q && result_stall;
		res_sortable_d = res_sortable_q;
		res_ovf_d      = res_ovf_q;
		mem_we         = 1'b0;
		mem_waddr      = count_q[AW-1:0];
		mem_re         = 1'b0;
		mem_raddr      = count_dec[AW-1:0] - AW'(1);

		case (state_q)
			sssc_pkg::ST_IDLE: begin
				if (accept) begin
					draining_d = 1'b0;
					state_d    = sssc_pkg::ST_TAKE;
				end
			end

			sssc_pkg::ST_TAKE: begin
				state_d = last_q ? sssc_pkg::ST_FINAL : sssc_pkg::ST_IDLE;
				if (failed_q) begin
					// The rest of a failed run is ignored.
				end else if (!draining_q && ({1'b0, value_q} == exp_q)) begin
					exp_d = exp_q + EW'(1);
				end else if (!stack_empty && top_is_exp) begin
					// Pop a matching top and look again at the new one.
					count_d    = count_dec;
					exp_d      = exp_q + EW'(1);
					draining_d = 1'b1;
					if (count_dec != '0) begin
						mem_re  = 1'b1;
						ret_d   = sssc_pkg::ST_TAKE;
						state_d = sssc_pkg::ST_POP_WAIT;
					end else begin
						state_d = sssc_pkg::ST_TAKE;
					end
				end else if (!stack_empty && (top_q < value_q)) begin
					failed_d = 1'b1;
				end else if (stack_full) begin
					ovf_d = 1'b1;
				end else begin
					mem_we  = 1'b1;
					top_d   = value_q;
					count_d = count_q + CW'(1);
				end
			end

			sssc_pkg::ST_POP_WAIT: begin
				top_d   = rd_data_q;
				state_d = ret_q;
			end

			sssc_pkg::ST_FINAL: begin
				if (failed_q || stack_empty) begin
					state_d = sssc_pkg::ST_EMIT;
				end else if (!top_is_exp) begin
					failed_d = 1'b1;
					state_d  = sssc_pkg::ST_EMIT;
				end else begin
					count_d = count_dec;
					exp_d   = exp_q + EW'(1);
					if (count_dec != '0) begin
						mem_re  = 1'b1;
						ret_d   = sssc_pkg::ST_FINAL;
						state_d = sssc_pkg::ST_POP_WAIT;
					end
				end
			end

			sssc_pkg::ST_EMIT: begin
				if (slot_free) begin
					res_valid_d    = 1'b1;
					res_sortable_d = !failed_q && (exp_q == ({1'b0, length_q} + EW'(1)));
					res_ovf_d      = ovf_q;
					// Start a fresh run; the length register is kept.
					count_d        = '0;
					exp_d          = EW'(1);
					failed_d       = 1'b0;
					ovf_d          = 1'b0;
					state_d        = sssc_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = sssc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- verif/stack_sortable_sequence_check_tb.sv -----
// Self-checking testbench for stack_sortable_sequence_check.
// Needs sssc_pkg and the block itself; a scoreboard class predicts each verdict and checks it.

module stack_sortable_sequence_check_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sssc_pkg::*;

	localparam int unsigned STACK_DEPTH = 128;
	// Requests to send in all, the directed ones included, before the random stimulus stops.
	localparam int ITEM_GOAL = 950;
	// Cycles allowed to pass before a register write, and after the last verdict.
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 30;
	// A drain of a full stack pops one entry at a time with no request moving, yet stays well
	// short of WATCHDOG_LIMIT quiet cycles, so reaching it can only mean a hang.
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int IDLE_PERCENT = 10;

	typedef struct packed {
		logic sortable;
		logic overflowed;
	} verdict_t;

	// Predicts the verdict of every run from the requests that the block accepts and
	// compares each result request with the oldest prediction still due.
	class sort_verdict_tracker;
		logic [VALUE_W-1:0] held [STACK_DEPTH];
		int unsigned held_count;
		logic [EXP_W-1:0] next_wanted;
		bit run_broken;
		bit push_dropped;
		logic [VALUE_W-1:0] run_length;
		verdict_t due[$];
		int unsigned failures;

		function new();
			run_length = '0;
			failures = 0;
			restart();
		endfunction

		function void restart();
			held_count = 0;
			next_wanted = EXP_W'(1);
			run_broken = 1'b0;
			push_dropped = 1'b0;
		endfunction

		function void set_length(logic [VALUE_W-1:0] n);
			run_length = n;
		endfunction

		function int unsigned outstanding();
			return due.size();
		endfunction

		function void note_request(logic [VALUE_W-1:0] v, logic is_last);
			verdict_t want;
			if (!run_broken) begin
				if ({1'b0, v} == next_wanted) begin
					next_wanted++;
				end else begin
					// Let out whatever the stack can give before deciding on v.
					while (held_count > 0 && {1'b0, held[held_count-1]} == next_wanted) begin
						held_count--;
						next_wanted++;
					end
					if (held_count > 0 && held[held_count-1] < v) begin
						run_broken = 1'b1;
					end else if (held_count >= STACK_DEPTH) begin
						push_dropped = 1'b1;
					end else begin
						held[held_count] = v;
						held_count++;
					end
				end
			end
			if (is_last) begin
				if (!run_broken) begin
					while (held_count > 0) begin
						if ({1'b0, held[held_count-1]} != next_wanted) begin
							run_broken = 1'b1;
							break;
						end
						held_count--;
						next_wanted++;
					end
				end
				want.sortable = !run_broken && next_wanted == {1'b0, run_length} + EXP_W'(1);
				want.overflowed = push_dropped;
				due.push_back(want);
				restart();
			end
		endfunction

		function void check_verdict(logic got_sortable, logic got_overflowed);
			verdict_t want;
			if (due.size() == 0) begin
				$error("verdict with none expected: sortable=%0b stack_overflowed=%0b",
					got_sortable, got_overflowed);
				failures++;
				return;
			end
			want = due.pop_front();
			if (got_sortable !== want.sortable) begin
				$error("sortable: expected %0b, actual %0b", want.sortable, got_sortable);
				failures++;
			end
			if (got_overflowed !== want.overflowed) begin
				$error("stack_overflowed: expected %0b, actual %0b",
					want.overflowed, got_overflowed);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sequence_length_we = 1'b0;
	logic [VALUE_W-1:0] sequence_length_wdata = '0;
	logic value_valid = 1'b0;
	logic value_stall;
	logic [VALUE_W-1:0] value = '0;
	logic last = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic sortable;
	logic stack_overflowed;

	sort_verdict_tracker board = new();

	// While steady is set neither side idles, so requests are offered with no gaps between them.
	bit steady = 1'b0;
	int items_sent = 0;
	int unsigned quiet_cycles = 0;
	logic [VALUE_W-1:0] run_q[$];

	stack_sortable_sequence_check #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sequence_length_we(sequence_length_we),
		.sequence_length_wdata(sequence_length_wdata),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.value(value),
		.last(last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sortable(sortable),
		.stack_overflowed(stack_overflowed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The result side stalls at random, with a chance of IDLE_PERCENT percent, except during the steady stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Every result request taken at this edge is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			board.check_verdict(sortable, stack_overflowed);
		end
	end

	// Progress means a request moving on either channel or a register write; anything
	// else for too long is treated as a hang.
	always @(posedge clk) begin
		if (!arst_n || (value_valid && !value_stall) || (result_valid && !result_stall)
				|| sequence_length_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Offers one request, with a random idle gap first, and returns at the edge that
	// accepts it. The payload is held for as long as the block stalls.
	task automatic send_request(input logic [VALUE_W-1:0] v, input logic is_last);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			value_valid <= 1'b0;
			@(posedge clk);
		end
		value_valid <= 1'b1;
		value <= v;
		last <= is_last;
		@(posedge clk);
		while (value_stall) @(posedge clk);
		board.note_request(v, is_last);
		items_sent++;
	endtask

	task automatic send_run();
		foreach (run_q[i]) send_request(run_q[i], i == run_q.size() - 1);
	endtask

	// The register may only change with no run in flight: every verdict must be back and
	// the block given a few cycles to settle before the write.
	task automatic program_length(input logic [VALUE_W-1:0] n);
		value_valid <= 1'b0;
		while (board.outstanding() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		sequence_length_we <= 1'b1;
		sequence_length_wdata <= n;
		@(posedge clk);
		sequence_length_we <= 1'b0;
		board.set_length(n);
	endtask

	// A stack-sortable arrangement of 1..n: the first value k is followed by an arrangement
	// of everything below k and then of everything above it. Anything greater than k
	// arriving while k is still held would break the run.
	function automatic void build_sortable(int n);
		int lo_q[$];
		int hi_q[$];
		int lo;
		int hi;
		int k;
		run_q.delete();
		lo_q.push_front(1);
		hi_q.push_front(n);
		while (lo_q.size() > 0) begin
			lo = lo_q.pop_front();
			hi = hi_q.pop_front();
			k = $urandom_range(hi, lo);
			run_q.push_back(VALUE_W'(k));
			if (k < hi) begin
				lo_q.push_front(k + 1);
				hi_q.push_front(hi);
			end
			if (k > lo) begin
				lo_q.push_front(lo);
				hi_q.push_front(k - 1);
			end
		end
	endfunction

	function automatic void build_shuffled(int n);
		int j;
		logic [VALUE_W-1:0] swap;
		run_q.delete();
		for (int k = 1; k <= n; k++) run_q.push_back(VALUE_W'(k));
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(k);
			swap = run_q[k];
			run_q[k] = run_q[j];
			run_q[j] = swap;
		end
	endfunction

	// Half the values near the run's range, half anywhere in the field.
	function automatic void build_noise(int n);
		run_q.delete();
		repeat (n) begin
			if ($urandom_range(1))
				run_q.push_back(VALUE_W'($urandom_range(n + 1)));
			else
				run_q.push_back(VALUE_W'($urandom_range(16'hFFFF)));
		end
	endfunction

	// A sortable run with at most one fault: two values swapped or one value replaced.
	function automatic void build_tampered(int n);
		int a;
		int b;
		logic [VALUE_W-1:0] swap;
		build_sortable(n);
		a = $urandom_range(n - 1);
		b = $urandom_range(n - 1);
		if ($urandom_range(1)) begin
			swap = run_q[a];
			run_q[a] = run_q[b];
			run_q[b] = swap;
		end else begin
			run_q[a] = VALUE_W'($urandom_range(n + 1));
		end
	endfunction

	// Descending from n holds n-1 values at once, which overflows a stack of
	// STACK_DEPTH once n passes STACK_DEPTH + 1.
	function automatic void build_descending(int n);
		run_q.delete();
		for (int k = n; k >= 1; k--) run_q.push_back(VALUE_W'(k));
	endfunction

	initial begin
		int pick;
		int runs;
		int n;
		int run_len;
		bit first_phase;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A run of one that is exactly 1 is sortable; a repeated value can
		// never leave the stack in order.
		program_length(16'd1);
		run_q = '{16'd1};
		send_run();
		run_q = '{16'hFFFF};
		send_run();
		run_q = '{16'd1, 16'd1};
		send_run();

		// Four orders that differ in kind: held then drained at the end, the one
		// pattern that fails on arrival (a larger value over a smaller held one, after
		// which the rest is ignored), a full descent, and a final drain that does not match.
		program_length(16'd3);
		run_q = '{16'd3, 16'd1, 16'd2};
		send_run();
		run_q = '{16'd2, 16'd3, 16'd1};
		send_run();
		run_q = '{16'd3, 16'd2, 16'd1};
		send_run();
		run_q = '{16'd1, 16'd3};
		send_run();

		// Register extremes: a length of zero can never succeed, nor can a short run reach
		// the largest length.
		program_length(16'd0);
		run_q = '{16'd0};
		send_run();
		program_length(16'hFFFF);
		run_q = '{16'd1, 16'd2};
		send_run();
		run_q = '{16'hFFFF, 16'd0};
		send_run();

		// Random part, in phases of one register setting each. The first phase overflows
		// the stack so that the dropped-push case is always seen.
		first_phase = 1'b1;
		while (items_sent < ITEM_GOAL) begin
			steady <= (items_sent >= 450 && items_sent < 650);
			pick = $urandom_range(99);
			if (first_phase || pick < 4) begin
				n = $urandom_range(STACK_DEPTH + 22, STACK_DEPTH + 2);
				program_length(VALUE_W'(n));
				build_descending(n);
				send_run();
				build_sortable(n);
				send_run();
			end else begin
				if (pick < 10)
					n = $urandom_range(1) ? 16'hFFFF : 0;
				else
					n = $urandom_range(12, 1);
				program_length(VALUE_W'(n));
				runs = $urandom_range(8, 3);
				repeat (runs) begin
					// Mostly runs as long as the register says, sometimes not.
					if (n >= 1 && n <= 12 && $urandom_range(99) < 80)
						run_len = n;
					else
						run_len = $urandom_range(12, 1);
					pick = $urandom_range(99);
					if (pick < 55)
						build_sortable(run_len);
					else if (pick < 70)
						build_shuffled(run_len);
					else if (pick < 80)
						build_noise(run_len);
					else if (pick < 92)
						build_tampered(run_len);
					else
						build_descending(run_len);
					send_run();
				end
			end
			first_phase = 1'b0;
		end
		steady <= 1'b0;

		value_valid <= 1'b0;
		while (board.outstanding() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
sv/sssc_pkg.sv
sv/stack_sortable_sequence_check.sv
verif/stack_sortable_sequence_check_tb.sv
